/* sv/tcw_pkg.sv */
// Shared constants, types and codes of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELL_COUNT     = ROWS * COLUMNS;
  localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

  // Internal widths
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int WORD_W  = COLOR_W + CHAR_W;

  // Stream data widths, whole bytes
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;

  typedef enum logic {
    FUNC_PUT  = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } ctl_state_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_CLEAR,
    MEM_COPY,
    MEM_DRAIN,
    MEM_FILL
  } mem_op_e;

  typedef struct packed {
    logic    take;
    logic    cnt_copy;
    logic    cnt_fill;
    logic    cnt_inc;
    mem_op_e mem_op;
    logic    load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic take_scroll;
    logic cnt_last;
  } dp_status_t;

endpackage

/* sv/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tcw_ctrl.sv */
// Sequencer of the text console writer: clear pass, item handling, scroll.
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  ctl_state_e state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = s_axis_tvalid && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.cnt_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.take_scroll ? ST_COPY : ST_DONE;
        end
      end
      ST_COPY:  if (status_i.cnt_last) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FILL;
      ST_FILL:  if (status_i.cnt_last) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mem_op   = MEM_NONE;
    s_axis_tready  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_op  = MEM_CLEAR;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready  = 1'b1;
        cmd_o.take     = accept;
        cmd_o.cnt_copy = accept && status_i.take_scroll;
      end
      ST_COPY: begin
        cmd_o.mem_op  = MEM_COPY;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.mem_op   = MEM_DRAIN;
        cmd_o.cnt_fill = 1'b1;
      end
      ST_FILL: begin
        cmd_o.mem_op  = MEM_FILL;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_DONE: cmd_o.load_out = out_free;
      default: cmd_o.mem_op = MEM_NONE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

/* sv/tcw_dpath.sv */
// Datapath: cursor, color, sweep counter, screen RAM and result register.
module tcw_dpath
  import tcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  ctl_cmd_t             cmd_i,
  output dp_status_t           status_o
);

  logic [COLOR_W-1:0] color_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic               cp_valid_q;
  logic [ADDR_W-1:0]  cp_dst_q;
  logic               rd_hit_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [WORD_W-1:0]  out_word_q;

  logic [CHAR_W-1:0]  in_char;
  logic [IDX_W-1:0]   in_idx;
  func_e              in_func;
  logic               in_range;
  logic               is_nl;
  logic               wrap;
  logic               row_end;
  logic               do_put;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  assign in_char  = s_axis_tdata[CHAR_W-1:0];
  assign in_idx   = s_axis_tdata[CHAR_W +: IDX_W];
  assign in_func  = func_e'(s_axis_tuser);
  assign in_range = 32'(in_idx) < 32'(CELL_COUNT);

  // cursor advance for a put
  assign is_nl   = in_char == NEWLINE_CHAR;
  assign wrap    = is_nl || (col_q == COL_W'(COLUMNS - 1));
  assign row_end = row_q == ROW_W'(ROWS - 1);
  assign do_put  = cmd_i.take && (in_func == FUNC_PUT);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    if (do_put) begin
      if (wrap) begin
        col_d = '0;
        if (row_end) begin
          pos_d = ADDR_W'(LAST_ROW_START);
        end else begin
          row_d = row_q + ROW_W'(1);
          pos_d = pos_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
        end
      end else begin
        col_d = col_q + COL_W'(1);
        pos_d = pos_q + ADDR_W'(1);
      end
    end
  end

  assign status_o.take_scroll = (in_func == FUNC_PUT) && wrap && row_end;
  assign status_o.cnt_last    = cnt_q == ADDR_W'(CELL_COUNT - 1);

  // sweep counter
  always_comb begin
    priority if (cmd_i.cnt_copy) begin
      cnt_d = ADDR_W'(COLUMNS);
    end else if (cmd_i.cnt_fill) begin
      cnt_d = ADDR_W'(LAST_ROW_START);
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + ADDR_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  // RAM port steering
  always_comb begin
    unique case (cmd_i.mem_op)
      MEM_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
      end
      MEM_COPY, MEM_DRAIN: begin
        ram_we    = cp_valid_q;
        ram_waddr = cp_dst_q;
        ram_wdata = ram_rdata;
      end
      MEM_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {color_q, BLANK_CHAR};
      end
      default: begin
        ram_we    = do_put && !is_nl;
        ram_waddr = pos_q;
        ram_wdata = {color_q, in_char};
      end
    endcase
  end

  assign ram_re    = (cmd_i.mem_op == MEM_COPY) ||
                     (cmd_i.take && (in_func == FUNC_READ) && in_range);
  assign ram_raddr = (cmd_i.mem_op == MEM_COPY) ? cnt_q : ADDR_W'(in_idx);

  tcw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q    <= COLOR_RESET;
      col_q      <= '0;
      row_q      <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      cp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      cp_valid_q <= cmd_i.mem_op == MEM_COPY;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cp_dst_q <= cnt_q - ADDR_W'(COLUMNS);
    if (cmd_i.take) begin
      rd_hit_q <= (in_func == FUNC_READ) && in_range;
    end
    if (cmd_i.load_out) begin
      out_pos_q  <= POS_W'(pos_q);
      out_word_q <= rd_hit_q ? ram_rdata : '0;
    end
  end

  assign m_axis_tdata = {(M_TDATA_W - POS_W - WORD_W)'(0), out_word_q, out_pos_q};

endmodule

/* sv/text_console_writer.sv */
// Top level of the text console writer: sequencer plus datapath.
//
// Character-cell text console of COLUMNS x ROWS cells (80 x 25), each cell a
// 16-bit word with the color byte high and the character byte low. An item
// with tuser = 0 puts tdata[7:0] at the cursor in the current color and
// advances the cursor; byte 0x0A is a newline and stores nothing. Moving past
// the last row scrolls the screen up one row and fills the bottom row with
// blanks in the current color. An item with tuser = 1 reads the cell at
// tdata[18:8]; an index at or beyond the cell count reads as zero and a read
// leaves cursor and screen alone. Every item gives exactly one result: the
// linear cursor position after the item and the read cell (zero for puts).
// Sequence: after reset the screen RAM is swept to zero, one cell per cycle, so
// no item is taken until the sweep is done; color writes are taken meanwhile.
// A read or a put that does not scroll goes from IDLE to DONE, where the
// result is loaded into the output register once that register is free or
// being emptied, and the sequencer then returns to IDLE for the next item.
// A scrolling put adds the row move over the single-write-port screen RAM,
// one cell per cycle: a copy pass that moves the rows up, a drain step for the
// last copied cell and a fill pass over the bottom row, then DONE. One item
// is in work at a time; the next item is taken while a finished result still
// waits in the output register. Write the color only while no item is in work.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] char_code, [18:8] cell_index
  input  logic                 s_axis_tuser,  // [0] func
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [10:0] cursor_position, [26:11] cell_word
  // color register
  input  logic                 cfg_we_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: clear sweep, handshakes, scroll sequence
  tcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // cursor, color, screen RAM and result register
  tcw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_axis_tdata(m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* sv/tcw_checker.sv */
// Port-level checker of the text console writer and its bind.
module tcw_checker
  import tcw_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[POS_W-1:0]) < 32'(CELL_COUNT))
    else $error("cursor position beyond screen");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without an item");

  a_ready_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> pend_q <= 2'd1)
    else $error("item taken with two results outstanding");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

/* tb/sv/text_console_writer_checker.sv */
// Checker for the text console writer: watches all ports, predicts and compares results.
module text_console_writer_checker
  import tcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [S_TDATA_W-1:0] in_data_i,    // [7:0] char_code, [18:8] cell_index
  input  logic                 in_user_i,    // [0] func
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [M_TDATA_W-1:0] res_data_i,   // [10:0] cursor_position, [26:11] cell_word
  input  logic                 cfg_we_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i,
  output int                   err_count_o,
  output int                   outstanding_o,
  output int                   scroll_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } console_result_t;

  // shadow copy of the console
  logic [WORD_W-1:0]  screen_shadow [CELL_COUNT];
  logic [COLOR_W-1:0] color_shadow;
  int                 col_shadow;
  int                 row_shadow;
  console_result_t    expected_results [$];

  // Apply one item to the shadow console and return the result it must give.
  task automatic console_step(input func_e f, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx, output console_result_t r);
    int i;
    r.word = '0;
    if (f == FUNC_PUT) begin
      if (ch == NEWLINE_CHAR) begin
        col_shadow = 0;
        row_shadow++;
      end else begin
        screen_shadow[row_shadow * COLUMNS + col_shadow] = {color_shadow, ch};
        col_shadow++;
      end
      if (col_shadow >= COLUMNS) begin
        col_shadow = 0;
        row_shadow++;
      end
      if (row_shadow >= ROWS) begin
        // scroll: rows move up one, bottom row becomes blanks in the current color
        for (i = 0; i < LAST_ROW_START; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (i = LAST_ROW_START; i < CELL_COUNT; i++)
          screen_shadow[i] = {color_shadow, BLANK_CHAR};
        row_shadow = ROWS - 1;
        scroll_count_o++;
      end
    end else if (idx < CELL_COUNT) begin
      r.word = screen_shadow[idx];
    end
    r.pos = POS_W'(row_shadow * COLUMNS + col_shadow);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    console_result_t got;
    console_result_t want;
    int i;
    if (!rst_ni) begin
      for (i = 0; i < CELL_COUNT; i++) screen_shadow[i] = '0;
      color_shadow   = COLOR_RESET;
      col_shadow     = 0;
      row_shadow     = 0;
      err_count_o    = 0;
      scroll_count_o = 0;
      expected_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.pos  = res_data_i[POS_W-1:0];
        got.word = res_data_i[POS_W +: WORD_W];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, actual pos %0d word %h", $time,
                   got.pos, got.word);
          err_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.pos !== want.pos) begin
            $display("%0t: cursor_position mismatch, expected %0d actual %0d", $time,
                     want.pos, got.pos);
            err_count_o++;
          end
          if (got.word !== want.word) begin
            $display("%0t: cell_word mismatch, expected %h actual %h", $time,
                     want.word, got.word);
            err_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        console_step(func_e'(in_user_i), in_data_i[CHAR_W-1:0],
                     in_data_i[CHAR_W +: IDX_W], want);
        expected_results.push_back(want);
      end
      // a color write lands after this edge, so an item taken now sees the old one
      if (cfg_we_i) color_shadow = cfg_wdata_i;
    end
    outstanding_o <= expected_results.size();
  end

endmodule

/* tb/sv/text_console_writer_tb.sv */
// Testbench top for the text console writer: stimulus, result sink, watchdog, verdict.
module text_console_writer_tb;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest correct silence: the clear sweep after reset or a scroll, plus the
  // random idle gaps on each side. The limit is several times over.
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 200;

  logic                 clk_i;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [S_TDATA_W-1:0] in_data   = '0;   // [7:0] char_code, [18:8] cell_index
  logic                 in_user   = 1'b0;  // [0] func
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic [M_TDATA_W-1:0] res_data;          // [10:0] cursor_position, [26:11] cell_word
  logic                 cfg_we    = 1'b0;
  logic [COLOR_W-1:0]   cfg_wdata = '0;

  int err_count;
  int outstanding;
  int scroll_count;
  int items_sent   = 0;
  int reads_sent   = 0;
  int color_writes = 0;
  int stall_cycles = 0;
  bit send_calm    = 1'b0;

  text_console_writer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_data),
    .s_axis_tuser (in_user),
    .m_axis_tvalid(res_valid),
    .m_axis_tready(res_ready),
    .m_axis_tdata (res_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  text_console_writer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .in_user_i     (in_user),
    .res_valid_i   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_i    (res_data),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .err_count_o   (err_count),
    .outstanding_o (outstanding),
    .scroll_count_o(scroll_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Send one item. The gap is drawn per item; calm stretches send back to back.
  // valid stays high across back-to-back items, so it is never lowered and
  // raised in the same step.
  task automatic send_item(input func_e f, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {{(S_TDATA_W - CHAR_W - IDX_W){1'b0}}, idx, ch};
    in_user  <= f;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    if (f == FUNC_READ) reads_sent++;
  endtask

  // Color writes only while the console is idle: wait until every expected
  // result has come back. outstanding is a register that lags the last
  // acceptance, so the loop steps the clock before it first reads it.
  task automatic set_color(input logic [COLOR_W-1:0] c);
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    color_writes++;
  endtask

  // Random mix: single puts and reads, long text runs that wrap at the right
  // edge, and runs of newlines that drive the cursor to the bottom and scroll.
  task automatic random_phase(input int n);
    int k;
    int sel;
    int run;
    int where;
    logic [IDX_W-1:0] idx;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        run = $urandom_range(1, 30);
        repeat (run) send_item(FUNC_PUT, NEWLINE_CHAR, IDX_W'($urandom_range(0, 2047)));
        k += run;
      end else if (sel < 3) begin
        run = $urandom_range(60, 170);
        repeat (run)
          send_item(FUNC_PUT, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
        k += run;
      end else if (sel < 35) begin
        // reads: anywhere, the bottom rows where scrolls leave blanks, or out of range
        where = $urandom_range(0, 9);
        if (where < 5)      idx = IDX_W'($urandom_range(0, 2047));
        else if (where < 8) idx = IDX_W'($urandom_range(LAST_ROW_START - COLUMNS, CELL_COUNT - 1));
        else                idx = IDX_W'($urandom_range(CELL_COUNT, 2047));
        send_item(FUNC_READ, CHAR_W'($urandom_range(0, 255)), idx);
        k++;
      end else if (sel < 40) begin
        send_item(FUNC_PUT, NEWLINE_CHAR, IDX_W'($urandom_range(0, 2047)));
        k++;
      end else begin
        send_item(FUNC_PUT, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
        k++;
      end
    end
  endtask

  // Result sink: ready drops for a random number of cycles before each result,
  // with calm stretches where it stays high.
  initial begin : result_sink
    int gap;
    bit calm;
    calm = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ready <= 1'b1;
      do @(posedge clk_i); while (!res_valid);
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed part, reset color. Items wait out the clearing sweep.
    send_item(FUNC_READ, 8'hFF, 11'd0);      // cleared cell reads zero
    send_item(FUNC_READ, 8'h00, 11'd1999);   // last cell
    send_item(FUNC_READ, 8'hFF, 11'd2000);   // first index out of range
    send_item(FUNC_READ, 8'h00, 11'd2047);   // top of the index field
    send_item(FUNC_PUT,  8'h00, 11'd2047);   // lowest byte
    send_item(FUNC_PUT,  8'hFF, 11'd0);      // highest byte
    send_item(FUNC_PUT,  8'h7F, 11'h555);
    send_item(FUNC_PUT,  8'h80, 11'h2AA);
    send_item(FUNC_READ, 8'h00, 11'd0);      // read back; cursor must not move
    send_item(FUNC_READ, 8'h00, 11'd1);
    send_item(FUNC_READ, 8'h00, 11'd3);
    send_item(FUNC_PUT,  NEWLINE_CHAR, 11'd0);  // newline mid-row
    send_item(FUNC_PUT,  NEWLINE_CHAR, 11'd0);  // newline at column 0
    send_item(FUNC_READ, 8'h00, 11'(COLUMNS));  // newline stored nothing
    send_item(FUNC_PUT,  BLANK_CHAR, 11'd0);
    send_item(FUNC_PUT,  8'h09, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'(2 * COLUMNS));
    send_item(FUNC_READ, 8'h00, 11'(2 * COLUMNS + 1));

    // Random phases, each under its own color; the extremes come first.
    set_color(8'h00);
    random_phase(PHASE_ITEMS);
    set_color(8'hFF);
    random_phase(PHASE_ITEMS);
    repeat (3) begin
      set_color(COLOR_W'($urandom_range(0, 255)));
      random_phase(PHASE_ITEMS);
    end

    // Drain, then give a stray result a chance to show up.
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d items (%0d reads) under %0d color settings,", items_sent,
             reads_sent, color_writes + 1);
    $display("including %0d screen scrolls.", scroll_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_dpath.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/sv/text_console_writer_checker.sv
tb/sv/text_console_writer_tb.sv
